// ----- rtl/core/scd_pkg.sv -----
// Shared constants, types and helpers of the stick calibration and deadband block.
package scd_pkg;

	// Fixed-point format of stick positions
	localparam int FRAC_BITS = 15;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam logic [VAL_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [VAL_W-1:0] HALF = ONE >> 1;

	// Port field widths
	localparam int DATA_W = 16;
	localparam int MODE_W = 2;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	// Internal widths: magnitudes, signed working values, divisor, quotient, remainder
	localparam int MAG_W = (VAL_W > DATA_W) ? VAL_W : DATA_W;
	localparam int SX_W  = MAG_W + 2;
	localparam int DEN_W = MAG_W + 1;
	localparam int QW    = VAL_W;
	localparam int DW_W  = DEN_W + QW + 1;

	// Mode codes; the upper mode bit turns the deadband on
	localparam logic [MODE_W-1:0] MODE_RAW = 2'd0;
	localparam int MODE_DB_BIT = 1;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CAL_MIN    = 3'd0,
		REG_CAL_CENTER = 3'd1,
		REG_CAL_MAX    = 3'd2,
		REG_DB_WIDTH   = 3'd3,
		REG_DB_MIDDLE  = 3'd4
	} scd_reg_t;

	// Register reset values
	localparam logic [CFG_W-1:0] CAL_MIN_RST    = 16'd0;
	localparam logic [CFG_W-1:0] CAL_CENTER_RST = 16'd16384;
	localparam logic [CFG_W-1:0] CAL_MAX_RST    = 16'd32768;
	localparam logic [CFG_W-1:0] DB_WIDTH_RST   = 16'd0;
	localparam logic             DB_MIDDLE_RST  = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] cal_min;
		logic [CFG_W-1:0] cal_center;
		logic [CFG_W-1:0] cal_max;
		logic [CFG_W-1:0] db_width;
		logic             db_middle;
	} scd_cfg_t;

	// How a segment result is formed once the quotient is known
	typedef struct packed {
		logic             fixed;
		logic [VAL_W-1:0] fixed_val;
		logic             base_half;
		logic             negate;
		logic             do_db;
	} scd_ctl_t;

	typedef struct packed {
		scd_ctl_t         ctl;
		logic [DW_W-1:0]  num;
		logic [DEN_W-1:0] den;
	} scd_divreq_t;

	typedef struct packed {
		scd_ctl_t        ctl;
		logic [QW-1:0]   quot;
		logic            ovf;
	} scd_divres_t;

	typedef struct packed {
		logic [VAL_W-1:0] v;
		logic             do_db;
	} scd_val_t;

	// Magnitude of a signed working value
	function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SX_W-1:0] x);
		logic signed [SX_W-1:0] m;
		m = (x < 0) ? -x : x;
		return MAG_W'(m);
	endfunction

endpackage

// ----- rtl/core/scd_if.sv -----
// Valid/ready stream interfaces for stick requests and results.
interface scd_in_if;
	logic                         valid;
	logic                         ready;
	logic [scd_pkg::DATA_W-1:0]   sample;
	logic [scd_pkg::MODE_W-1:0]   mode;

	modport source (output valid, sample, mode, input ready);
	modport sink   (input valid, sample, mode, output ready);
endinterface

interface scd_out_if;
	logic                         valid;
	logic                         ready;
	logic [scd_pkg::DATA_W-1:0]   stick_value;

	modport source (output valid, stick_value, input ready);
	modport sink   (input valid, stick_value, output ready);
endinterface

// ----- rtl/core/scd_cal_front.sv -----
// Calibration stage: picks the segment of the raw sample and forms its divide request.
module scd_cal_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scd_pkg::scd_cfg_t           cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [scd_pkg::DATA_W-1:0]  sample,
	input  logic [scd_pkg::MODE_W-1:0]  mode,
	output logic                        req_valid,
	input  logic                        req_ready,
	output scd_pkg::scd_divreq_t        req
);
	localparam int SX    = scd_pkg::SX_W;
	localparam int DW_W  = scd_pkg::DW_W;
	localparam int VAL_W = scd_pkg::VAL_W;

	logic signed [SX-1:0] v, lo, mc, hi, rng_lo, num_lo, rng_hi, num_hi;
	scd_pkg::scd_divreq_t nxt;
	logic                 vld_s1;
	scd_pkg::scd_divreq_t req_s1;

	assign v      = SX'(sample);
	assign lo     = SX'(cfg.cal_min);
	assign mc     = SX'(cfg.cal_center);
	assign hi     = SX'(cfg.cal_max);
	assign rng_lo = mc - lo;
	assign num_lo = v - lo;
	assign rng_hi = hi - mc;
	assign num_hi = v - mc;

	// segment selection and special cases
	always_comb begin
		nxt = '0;
		nxt.ctl.do_db = mode[scd_pkg::MODE_DB_BIT];
		if (mode == scd_pkg::MODE_RAW) begin
			nxt.ctl.fixed = 1'b1;
			nxt.ctl.do_db = 1'b0;
			if (SX'(sample) > SX'(scd_pkg::ONE))
				nxt.ctl.fixed_val = scd_pkg::ONE;
			else
				nxt.ctl.fixed_val = VAL_W'(sample);
		end else if (v <= mc) begin
			// lower segment: zero range, zero offset or opposite signs give 0
			if (rng_lo == 0 || num_lo == 0 || ((num_lo < 0) != (rng_lo < 0))) begin
				nxt.ctl.fixed     = 1'b1;
				nxt.ctl.fixed_val = '0;
			end else begin
				nxt.num = DW_W'(scd_pkg::abs_mag(num_lo)) << scd_pkg::FRAC_BITS;
				nxt.den = {scd_pkg::abs_mag(rng_lo), 1'b0};
			end
		end else begin
			// upper segment: zero range pins to full travel
			if (rng_hi == 0) begin
				nxt.ctl.fixed     = 1'b1;
				nxt.ctl.fixed_val = scd_pkg::ONE;
			end else if (num_hi == 0) begin
				nxt.ctl.fixed     = 1'b1;
				nxt.ctl.fixed_val = scd_pkg::HALF;
			end else begin
				nxt.ctl.base_half = 1'b1;
				nxt.ctl.negate    = (rng_hi < 0);
				nxt.num = DW_W'(scd_pkg::abs_mag(num_hi)) << scd_pkg::FRAC_BITS;
				nxt.den = {scd_pkg::abs_mag(rng_hi), 1'b0};
			end
		end
	end

	assign in_ready = !vld_s1 || req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= nxt;
		end
	end

	assign req_valid = vld_s1;
	assign req       = req_s1;
endmodule

// ----- rtl/core/scd_db_front.sv -----
// Deadband stage: picks the deadband segment of a calibrated value and forms its divide request.
module scd_db_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scd_pkg::scd_cfg_t    cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  scd_pkg::scd_val_t    val,
	output logic                 req_valid,
	input  logic                 req_ready,
	output scd_pkg::scd_divreq_t req
);
	localparam int SX    = scd_pkg::SX_W;
	localparam int DW_W  = scd_pkg::DW_W;
	localparam int DEN_W = scd_pkg::DEN_W;

	logic signed [SX-1:0] vv, d, half, one, mc, xc, rng_hi, num_hi, den_le, num_le;
	scd_pkg::scd_divreq_t nxt;
	logic                 vld_s1;
	scd_pkg::scd_divreq_t req_s1;

	assign vv     = SX'(val.v);
	assign d      = SX'(cfg.db_width >> 1);
	assign half   = SX'(scd_pkg::HALF);
	assign one    = SX'(scd_pkg::ONE);
	assign mc     = half - d;
	assign xc     = half + d;
	assign rng_hi = one - xc;
	assign num_hi = vv - xc;
	assign den_le = one - d;
	assign num_le = vv - d;

	always_comb begin
		nxt = '0;
		if (!val.do_db) begin
			nxt.ctl.fixed     = 1'b1;
			nxt.ctl.fixed_val = val.v;
		end else if (cfg.db_middle) begin
			// centred deadband: plateau at half, both sides rescaled
			if (vv <= mc) begin
				if (mc == 0 || vv == 0) begin
					nxt.ctl.fixed     = 1'b1;
					nxt.ctl.fixed_val = '0;
				end else begin
					nxt.num = DW_W'(scd_pkg::abs_mag(vv)) << scd_pkg::FRAC_BITS;
					nxt.den = {scd_pkg::abs_mag(mc), 1'b0};
				end
			end else if (vv < xc) begin
				nxt.ctl.fixed     = 1'b1;
				nxt.ctl.fixed_val = scd_pkg::HALF;
			end else if (rng_hi == 0) begin
				nxt.ctl.fixed     = 1'b1;
				nxt.ctl.fixed_val = scd_pkg::ONE;
			end else if (num_hi == 0) begin
				nxt.ctl.fixed     = 1'b1;
				nxt.ctl.fixed_val = scd_pkg::HALF;
			end else begin
				nxt.ctl.base_half = 1'b1;
				nxt.ctl.negate    = (rng_hi < 0);
				nxt.num = DW_W'(scd_pkg::abs_mag(num_hi)) << scd_pkg::FRAC_BITS;
				nxt.den = {scd_pkg::abs_mag(rng_hi), 1'b0};
			end
		end else if (vv < d) begin
			// low-end deadband: zero below it
			nxt.ctl.fixed     = 1'b1;
			nxt.ctl.fixed_val = '0;
		end else if (den_le <= 0) begin
			nxt.ctl.fixed     = 1'b1;
			nxt.ctl.fixed_val = scd_pkg::ONE;
		end else begin
			nxt.num = DW_W'(scd_pkg::abs_mag(num_le)) << scd_pkg::FRAC_BITS;
			nxt.den = DEN_W'(den_le);
		end
	end

	assign in_ready = !vld_s1 || req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= nxt;
		end
	end

	assign req_valid = vld_s1;
	assign req       = req_s1;
endmodule

// ----- rtl/core/scd_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, flagging quotients that overflow.
module scd_div_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  scd_pkg::scd_divreq_t req,
	output logic                 res_valid,
	input  logic                 res_ready,
	output scd_pkg::scd_divres_t res
);
	localparam int QW    = scd_pkg::QW;
	localparam int DW_W  = scd_pkg::DW_W;
	localparam int DEN_W = scd_pkg::DEN_W;
	localparam int NST   = QW + 1;

	// per-stage registers, index is the stage number
	logic                 vld_s  [NST];
	logic [DW_W-1:0]      rem_s  [NST];
	logic [DEN_W-1:0]     den_s  [NST];
	logic [QW-1:0]        quot_s [NST];
	logic                 ovf_s  [NST];
	scd_pkg::scd_ctl_t    ctl_s  [NST];
	logic                 load   [NST+1];

	// a stage loads when it is empty or its successor loads
	assign load[NST] = res_ready;
	for (genvar k = 0; k < NST; k++) begin : g_load
		assign load[k] = !vld_s[k] || load[k+1];
	end

	assign req_ready = load[0];

	// entry stage: quotients that do not fit in QW bits are flagged as overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (load[0]) begin
			vld_s[0] <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0] && req_valid) begin
			rem_s[0]  <= req.num;
			den_s[0]  <= req.den;
			quot_s[0] <= '0;
			ovf_s[0]  <= req.num >= (DW_W'(req.den) << QW);
			ctl_s[0]  <= req.ctl;
		end
	end

	// one trial subtraction per stage, most significant bit first
	for (genvar k = 1; k < NST; k++) begin : g_bit
		localparam int B = QW - k;
		logic [DW_W-1:0] trial;
		logic            take;

		assign trial = DW_W'(den_s[k-1]) << B;
		assign take  = rem_s[k-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (load[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (load[k] && vld_s[k-1]) begin
				rem_s[k]  <= take ? (rem_s[k-1] - trial) : rem_s[k-1];
				den_s[k]  <= den_s[k-1];
				quot_s[k] <= quot_s[k-1] | ({{(QW-1){1'b0}}, take} << B);
				ovf_s[k]  <= ovf_s[k-1];
				ctl_s[k]  <= ctl_s[k-1];
			end
		end
	end

	assign res_valid = vld_s[NST-1];
	assign res.ctl   = ctl_s[NST-1];
	assign res.quot  = quot_s[NST-1];
	assign res.ovf   = ovf_s[NST-1];
endmodule

// ----- rtl/core/scd_seg_back.sv -----
// Segment result stage: adds the quotient to its base, or subtracts it, and clamps to 0..1.
module scd_seg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  scd_pkg::scd_divres_t dres,
	output logic                 out_valid,
	input  logic                 out_ready,
	output scd_pkg::scd_val_t    val
);
	localparam int QW    = scd_pkg::QW;
	localparam int VAL_W = scd_pkg::VAL_W;

	logic [QW-1:0]          q;
	logic signed [QW+1:0]   base, sum;
	scd_pkg::scd_val_t      nxt;
	logic                   vld_s1;
	scd_pkg::scd_val_t      val_s1;

	assign q    = dres.ovf ? '1 : dres.quot;
	assign base = dres.ctl.base_half ? (QW+2)'(scd_pkg::HALF) : '0;
	assign sum  = dres.ctl.negate ? (base - (QW+2)'(q)) : (base + (QW+2)'(q));

	// clamp to 0..ONE unless the result was settled up front
	always_comb begin
		nxt.do_db = dres.ctl.do_db;
		if (dres.ctl.fixed)
			nxt.v = dres.ctl.fixed_val;
		else if (sum < 0)
			nxt.v = '0;
		else if (sum > (QW+2)'(scd_pkg::ONE))
			nxt.v = scd_pkg::ONE;
		else
			nxt.v = VAL_W'(sum);
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			val_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign val       = val_s1;
endmodule

// ----- rtl/core/stick_calibration_deadband.sv -----
// Top level of the stick calibration and deadband block: registers and pipeline.
//
//  channel    dir  handshake        payload
//  stick_in   in   valid/ready      sample[15:0], mode[1:0]
//  stick_out  out  valid/ready      stick_value[15:0]
//  cfg        in   cfg_we           cfg_index[2:0], cfg_data[15:0]
//
// One request per cycle while the output is not stalled; values are Q1.15, and each passes the two
// bit-per-stage dividers (calibration segment, then deadband segment).
// Reset empties the pipeline and loads the register defaults.
// A stage holds while its successor is full and stalled; empty stages close up, so
// requests keep entering until every stage is occupied.
module stick_calibration_deadband (
	input  logic                        clk,
	input  logic                        arst_n,
	scd_in_if.sink                      stick_in,
	scd_out_if.source                   stick_out,
	input  logic                        cfg_we,
	input  logic [scd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [scd_pkg::CFG_W-1:0]   cfg_data
);
	scd_pkg::scd_cfg_t    cfg_q;

	logic                 c_req_valid, c_req_ready;
	scd_pkg::scd_divreq_t c_req;
	logic                 c_res_valid, c_res_ready;
	scd_pkg::scd_divres_t c_res;
	logic                 c_val_valid, c_val_ready;
	scd_pkg::scd_val_t    c_val;
	logic                 d_req_valid, d_req_ready;
	scd_pkg::scd_divreq_t d_req;
	logic                 d_res_valid, d_res_ready;
	scd_pkg::scd_divres_t d_res;
	scd_pkg::scd_val_t    d_val;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_min    <= scd_pkg::CAL_MIN_RST;
			cfg_q.cal_center <= scd_pkg::CAL_CENTER_RST;
			cfg_q.cal_max    <= scd_pkg::CAL_MAX_RST;
			cfg_q.db_width   <= scd_pkg::DB_WIDTH_RST;
			cfg_q.db_middle  <= scd_pkg::DB_MIDDLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scd_pkg::REG_CAL_MIN:    cfg_q.cal_min    <= cfg_data;
				scd_pkg::REG_CAL_CENTER: cfg_q.cal_center <= cfg_data;
				scd_pkg::REG_CAL_MAX:    cfg_q.cal_max    <= cfg_data;
				scd_pkg::REG_DB_WIDTH:   cfg_q.db_width   <= cfg_data;
				scd_pkg::REG_DB_MIDDLE:  cfg_q.db_middle  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// calibration: segment select, divide, combine
	scd_cal_front u_cal_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (stick_in.valid),
		.in_ready  (stick_in.ready),
		.sample    (stick_in.sample),
		.mode      (stick_in.mode),
		.req_valid (c_req_valid),
		.req_ready (c_req_ready),
		.req       (c_req)
	);

	scd_div_pipe u_cal_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (c_req_valid),
		.req_ready (c_req_ready),
		.req       (c_req),
		.res_valid (c_res_valid),
		.res_ready (c_res_ready),
		.res       (c_res)
	);

	scd_seg_back u_cal_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_res_valid),
		.in_ready  (c_res_ready),
		.dres      (c_res),
		.out_valid (c_val_valid),
		.out_ready (c_val_ready),
		.val       (c_val)
	);

	// deadband: segment select, divide, combine
	scd_db_front u_db_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (c_val_valid),
		.in_ready  (c_val_ready),
		.val       (c_val),
		.req_valid (d_req_valid),
		.req_ready (d_req_ready),
		.req       (d_req)
	);

	scd_div_pipe u_db_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (d_req_valid),
		.req_ready (d_req_ready),
		.req       (d_req),
		.res_valid (d_res_valid),
		.res_ready (d_res_ready),
		.res       (d_res)
	);

	scd_seg_back u_db_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_res_valid),
		.in_ready  (d_res_ready),
		.dres      (d_res),
		.out_valid (stick_out.valid),
		.out_ready (stick_out.ready),
		.val       (d_val)
	);

	assign stick_out.stick_value = scd_pkg::DATA_W'(d_val.v);
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the stick calibration and deadband block.
module tb;
	import scd_pkg::*;

	// Mode codes beyond the raw clamp; bit one of the mode turns the deadband on
	localparam logic [MODE_W-1:0] MODE_CAL    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DB     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DB_ALT = 2'd3;

	// Index with no register behind it; writes there must be dropped
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam longint UNIT      = longint'(ONE);
	localparam longint HALF_UNIT = longint'(HALF);

	// Pipeline depth: two pipelined dividers with their front and back stages
	localparam int PIPE_DEPTH = 2 * (QW + 3);

	localparam int SEGMENTS     = 12;
	localparam int SEG_REQUESTS = 150;

	typedef enum logic [1:0] {ROW_WRITE, ROW_KNOWN, ROW_PREDICT} row_kind_t;

	// value is the register data on write rows and the sample on request rows;
	// idx only matters on write rows, want only on known rows
	typedef struct packed {
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic [15:0]      value;
		logic [MODE_W-1:0] mode;
		logic [15:0]      want;
	} dir_row_t;

	localparam int DIR_ROWS = 41;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// reset calibration: raw clamp and calibrated extremes
		'{ROW_KNOWN,   REG_UNUSED,     16'd0,     MODE_RAW,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'hFFFF,  MODE_RAW,    16'd32768},
		'{ROW_KNOWN,   REG_UNUSED,     16'd32767, MODE_RAW,    16'd32767},
		'{ROW_KNOWN,   REG_UNUSED,     16'd0,     MODE_CAL,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd16384, MODE_CAL,    16'd16384},
		'{ROW_KNOWN,   REG_UNUSED,     16'd32768, MODE_CAL,    16'd32768},
		'{ROW_KNOWN,   REG_UNUSED,     16'hFFFF,  MODE_CAL,    16'd32768},
		'{ROW_KNOWN,   REG_UNUSED,     16'd16384, MODE_DB,     16'd16384},
		'{ROW_KNOWN,   REG_UNUSED,     16'hFFFF,  MODE_DB_ALT, 16'd32768},
		'{ROW_PREDICT, REG_UNUSED,     16'd8000,  MODE_CAL,    16'd0},
		// write to an unused index changes nothing
		'{ROW_WRITE,   REG_UNUSED,     16'h5A5A,  MODE_RAW,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd16384, MODE_CAL,    16'd16384},
		// both segments of zero range
		'{ROW_WRITE,   REG_CAL_MIN,    16'd20000, MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_CAL_CENTER, 16'd20000, MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_CAL_MAX,    16'd20000, MODE_RAW,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd20000, MODE_CAL,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd20001, MODE_CAL,    16'd32768},
		'{ROW_KNOWN,   REG_UNUSED,     16'd0,     MODE_CAL,    16'd0},
		// inverted calibration
		'{ROW_WRITE,   REG_CAL_MIN,    16'd30000, MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_CAL_CENTER, 16'd20000, MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_CAL_MAX,    16'd10000, MODE_RAW,    16'd0},
		'{ROW_PREDICT, REG_UNUSED,     16'd25000, MODE_CAL,    16'd0},
		'{ROW_PREDICT, REG_UNUSED,     16'd15000, MODE_CAL,    16'd0},
		'{ROW_PREDICT, REG_UNUSED,     16'hFFFF,  MODE_CAL,    16'd0},
		// centred deadband wider than the travel: flat at half
		'{ROW_WRITE,   REG_CAL_MIN,    16'd0,     MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_CAL_CENTER, 16'd16384, MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_CAL_MAX,    16'd32768, MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_DB_WIDTH,   16'hFFFF,  MODE_RAW,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd0,     MODE_DB,     16'd16384},
		'{ROW_KNOWN,   REG_UNUSED,     16'd32768, MODE_DB,     16'd16384},
		// centred deadband of exactly full travel: both outer segments empty
		'{ROW_WRITE,   REG_DB_WIDTH,   16'd32768, MODE_RAW,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd0,     MODE_DB,     16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd32768, MODE_DB,     16'd32768},
		'{ROW_KNOWN,   REG_UNUSED,     16'd16384, MODE_DB,     16'd16384},
		// low-end deadband, upper data bits of the flag write ignored
		'{ROW_WRITE,   REG_DB_MIDDLE,  16'hFFFE,  MODE_RAW,    16'd0},
		'{ROW_WRITE,   REG_DB_WIDTH,   16'hFFFF,  MODE_RAW,    16'd0},
		'{ROW_KNOWN,   REG_UNUSED,     16'd32768, MODE_DB,     16'd32768},
		'{ROW_KNOWN,   REG_UNUSED,     16'd32767, MODE_DB,     16'd0},
		'{ROW_WRITE,   REG_DB_WIDTH,   16'd1000,  MODE_RAW,    16'd0},
		'{ROW_PREDICT, REG_UNUSED,     16'd20000, MODE_DB,     16'd0},
		'{ROW_PREDICT, REG_UNUSED,     16'd5000,  MODE_DB_ALT, 16'd0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	scd_in_if  stick_in_bus ();
	scd_out_if stick_out_bus ();

	stick_calibration_deadband u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stick_in  (stick_in_bus),
		.stick_out (stick_out_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copy used for prediction, positions still owed by the block
	scd_cfg_t          cal_regs;
	logic [DATA_W-1:0] stick_value_q [$];
	int                err_count;
	int                src_idle_pct;
	int                snk_idle_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Prediction ---------------------------------------------------------

	function automatic longint to_unit(longint x);
		if (x < 0)
			return 0;
		if (x > UNIT)
			return UNIT;
		return x;
	endfunction

	// |num| / (2 |den|) in unit scale, truncated
	function automatic longint half_span(longint num, longint den);
		longint n;
		longint d;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		return (n * UNIT) / (2 * d);
	endfunction

	// Two linear segments: lo..mid_lo onto 0..half, mid_hi..hi onto half..one
	function automatic longint map_segments(longint v, longint lo, longint mid_lo,
			longint mid_hi, longint hi);
		longint span;
		longint ofs;
		longint pos;
		if (v <= mid_lo) begin
			span = mid_lo - lo;
			ofs  = v - lo;
			if (span == 0 || ofs == 0 || ((ofs < 0) != (span < 0)))
				pos = 0;
			else
				pos = half_span(ofs, span);
		end else if (v < mid_hi) begin
			pos = HALF_UNIT;
		end else begin
			span = hi - mid_hi;
			ofs  = v - mid_hi;
			if (span == 0)
				pos = UNIT;
			else if (ofs == 0)
				pos = HALF_UNIT;
			else if (span < 0)
				pos = HALF_UNIT - half_span(ofs, span);
			else
				pos = HALF_UNIT + half_span(ofs, span);
		end
		return to_unit(pos);
	endfunction

	function automatic logic [DATA_W-1:0] predict_stick(logic [DATA_W-1:0] s,
			logic [MODE_W-1:0] m);
		longint pos;
		longint half_db;
		longint span;
		if (m == MODE_RAW) begin
			pos = to_unit(longint'(s));
		end else begin
			pos = map_segments(longint'(s), longint'(cal_regs.cal_min),
				longint'(cal_regs.cal_center), longint'(cal_regs.cal_center),
				longint'(cal_regs.cal_max));
			if (m[MODE_DB_BIT]) begin
				half_db = longint'(cal_regs.db_width >> 1);
				if (cal_regs.db_middle) begin
					pos = map_segments(pos, 0, HALF_UNIT - half_db, HALF_UNIT + half_db, UNIT);
				end else if (pos < half_db) begin
					pos = 0;
				end else begin
					span = UNIT - half_db;
					if (span <= 0)
						pos = UNIT;
					else
						pos = to_unit(((pos - half_db) * UNIT) / span);
				end
			end
		end
		return pos[DATA_W-1:0];
	endfunction

	// Stimulus choices ---------------------------------------------------

	function automatic scd_cfg_t random_calibration();
		scd_cfg_t c;
		int a;
		int b;
		int e;
		case ($urandom_range(0, 3))
			0, 1: begin
				// well-ordered calibration, the usual case
				a = $urandom_range(0, 30000);
				b = a + $urandom_range(1, 20000);
				e = b + $urandom_range(1, 20000);
				if (e > 65535)
					e = 65535;
				c.cal_min    = 16'(a);
				c.cal_center = 16'(b);
				c.cal_max    = 16'(e);
			end
			2: begin
				c.cal_min    = 16'($urandom());
				c.cal_center = 16'($urandom());
				c.cal_max    = 16'($urandom());
			end
			default: begin
				// segments collapsed at random, either, both or neither
				c.cal_center = 16'($urandom());
				c.cal_min    = $urandom_range(0, 1) ? c.cal_center : 16'($urandom());
				c.cal_max    = $urandom_range(0, 1) ? c.cal_center : 16'($urandom());
			end
		endcase
		case ($urandom_range(0, 5))
			0:       c.db_width = 16'd0;
			1:       c.db_width = 16'd32768;
			2:       c.db_width = 16'hFFFF;
			3:       c.db_width = 16'($urandom());
			default: c.db_width = 16'($urandom_range(0, 32768));
		endcase
		c.db_middle = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic logic [DATA_W-1:0] pick_sample();
		int lo;
		int hi;
		logic [DATA_W-1:0] point;
		lo = cal_regs.cal_min;
		hi = cal_regs.cal_min;
		if (cal_regs.cal_center < lo) lo = cal_regs.cal_center;
		if (cal_regs.cal_max < lo) lo = cal_regs.cal_max;
		if (cal_regs.cal_center > hi) hi = cal_regs.cal_center;
		if (cal_regs.cal_max > hi) hi = cal_regs.cal_max;
		case ($urandom_range(0, 9))
			0, 1, 2: return 16'($urandom());
			3, 4: begin
				// just around a calibration point
				case ($urandom_range(0, 2))
					0:       point = cal_regs.cal_min;
					1:       point = cal_regs.cal_center;
					default: point = cal_regs.cal_max;
				endcase
				return point + 16'($urandom_range(0, 4)) - 16'd2;
			end
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode();
		case ($urandom_range(0, 15))
			0, 1:          return MODE_RAW;
			2, 3, 4, 5, 6: return MODE_CAL;
			15:            return MODE_DB_ALT;
			default:       return MODE_DB;
		endcase
	endfunction

	// Drivers --------------------------------------------------------------

	// Leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_CAL_MIN:    cal_regs.cal_min    = data;
			REG_CAL_CENTER: cal_regs.cal_center = data;
			REG_CAL_MAX:    cal_regs.cal_max    = data;
			REG_DB_WIDTH:   cal_regs.db_width   = data;
			REG_DB_MIDDLE:  cal_regs.db_middle  = data[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input scd_cfg_t c);
		write_reg(REG_CAL_MIN, c.cal_min);
		write_reg(REG_CAL_CENTER, c.cal_center);
		write_reg(REG_CAL_MAX, c.cal_max);
		write_reg(REG_DB_WIDTH, c.db_width);
		write_reg(REG_DB_MIDDLE, {15'($urandom()), c.db_middle});
		write_reg(REG_UNUSED, 16'($urandom()));
		cfg_we <= 1'b0;
	endtask

	task automatic send_request(input logic [DATA_W-1:0] s, input logic [MODE_W-1:0] m,
			input logic [DATA_W-1:0] want);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			stick_in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		stick_in_bus.valid  <= 1'b1;
		stick_in_bus.sample <= s;
		stick_in_bus.mode   <= m;
		do @(posedge clk); while (!stick_in_bus.ready);
		stick_value_q.push_back(want);
	endtask

	// Stop sending until the block has returned everything
	task automatic drain_requests();
		stick_in_bus.valid <= 1'b0;
		do @(posedge clk); while (stick_value_q.size() != 0);
	endtask

	// Receiver with random back-pressure
	always @(posedge clk)
		stick_out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	// Checking ---------------------------------------------------------------

	task automatic flag_error(input string msg);
		if (err_count < 10)
			$display("%s", msg);
		err_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && stick_out_bus.valid && stick_out_bus.ready) begin
			if (stick_value_q.size() == 0) begin
				flag_error($sformatf("unexpected stick_value %0d", stick_out_bus.stick_value));
			end else if (stick_value_q[0] !== stick_out_bus.stick_value) begin
				flag_error($sformatf("stick_value mismatch: expected %0d, got %0d",
					stick_value_q[0], stick_out_bus.stick_value));
				void'(stick_value_q.pop_front());
			end else begin
				void'(stick_value_q.pop_front());
			end
		end
	end

	// Main sequence ------------------------------------------------------------

	initial begin
		dir_row_t          row;
		scd_cfg_t          seg_cfg;
		logic [DATA_W-1:0] s;
		logic [MODE_W-1:0] m;
		logic [DATA_W-1:0] want;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_CAL_MIN;
		cfg_data            = '0;
		stick_in_bus.valid  = 1'b0;
		stick_in_bus.sample = '0;
		stick_in_bus.mode   = MODE_RAW;
		stick_out_bus.ready = 1'b0;
		err_count           = 0;
		src_idle_pct        = 6;
		snk_idle_pct        = 85;

		cal_regs.cal_min    = CAL_MIN_RST;
		cal_regs.cal_center = CAL_CENTER_RST;
		cal_regs.cal_max    = CAL_MAX_RST;
		cal_regs.db_width   = DB_WIDTH_RST;
		cal_regs.db_middle  = DB_MIDDLE_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows; writes only once the block is empty
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			if (row.kind == ROW_WRITE) begin
				if (i == 0 || DIR_TABLE[i-1].kind != ROW_WRITE)
					drain_requests();
				write_reg(row.idx, row.value);
				if (i + 1 == DIR_ROWS || DIR_TABLE[i+1].kind != ROW_WRITE)
					cfg_we <= 1'b0;
			end else begin
				want = (row.kind == ROW_KNOWN) ? row.want : predict_stick(row.value, row.mode);
				send_request(row.value, row.mode, want);
			end
		end

		// Random segments, each under its own calibration; idling regime per third
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / (SEGMENTS / 3))
				0: begin
					src_idle_pct = 6;
					snk_idle_pct = 85;
				end
				1: begin
					src_idle_pct = 85;
					snk_idle_pct = 6;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			if (seg == 0) begin
				seg_cfg = '0;
			end else if (seg == 5) begin
				seg_cfg = '1;
			end else begin
				seg_cfg = random_calibration();
			end
			drain_requests();
			program_regs(seg_cfg);
			for (int k = 0; k < SEG_REQUESTS; k++) begin
				s = pick_sample();
				m = pick_mode();
				send_request(s, m, predict_stick(s, m));
			end
		end

		drain_requests();
		repeat (PIPE_DEPTH) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/scd_pkg.sv
rtl/core/scd_if.sv
rtl/core/scd_cal_front.sv
rtl/core/scd_db_front.sv
rtl/core/scd_div_pipe.sv
rtl/core/scd_seg_back.sv
rtl/core/stick_calibration_deadband.sv
tb/tb.sv
